// ===== hw/rtl/tsring_pkg.sv =====
package tsring_pkg;

  // word field widths
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned STAMP_W   = 64;
  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned LAT_W     = 24;

  // capture latency after reset, in stamp units
  localparam logic [LAT_W-1:0] LATENCY_RESET = LAT_W'(33333);

  // input function codes
  localparam logic [FUNC_W-1:0] FUNC_RECORD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FILL   = 2'd2;

  // one ring entry as stored in memory
  typedef struct packed {
    logic [STAMP_W-1:0]   stamp;
    logic [PAYLOAD_W-1:0] payload;
  } sample_t;

endpackage

// ===== hw/rtl/timestamp_ring_nearest_lookup_core.sv =====
// Ring of RING_DEPTH timestamped pose samples held in one synchronous memory
// (stamp and payload side by side, one read port, one write port, read data
// registered). A record word writes at the head and advances it. A fill word
// writes every entry, one per cycle, and blocks input until done; it must come
// before the first lookup. A lookup word subtracts capture_latency (saturating
// at zero) and binary-searches the ring from the oldest entry, one memory read
// and one 64-bit compare per step, for the newest entry whose stamp is not after
// the query; with none, the oldest entry is returned. Input stays stalled until
// the search is through, so no new word is taken during a lookup. A finished
// result sits in an output register, so the next word is taken while it waits,
// but a second lookup holds in its last cycle until the register frees up.
module timestamp_ring_nearest_lookup_core #(
  parameter int unsigned RING_DEPTH = 128
) (
  input  logic                             clk,
  input  logic                             rst,

  input  logic                             cfg_wr_en,
  input  logic [tsring_pkg::LAT_W-1:0]     cfg_wr_data,

  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tsring_pkg::FUNC_W-1:0]    func,
  input  logic [tsring_pkg::STAMP_W-1:0]   stamp,
  input  logic [tsring_pkg::PAYLOAD_W-1:0] pose_payload,

  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tsring_pkg::PAYLOAD_W-1:0] found_payload,
  output logic [tsring_pkg::STAMP_W-1:0]   found_stamp
);

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FILL  = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]                           state;
  logic [AW-1:0]                        head_index;
  logic [tsring_pkg::LAT_W-1:0]         capture_latency;
  logic [AW-1:0]                        fill_idx;
  tsring_pkg::sample_t                  fill_word;
  logic [tsring_pkg::STAMP_W-1:0]       query;
  logic [CW-1:0]                        lo;
  logic [CW-1:0]                        hi;

  tsring_pkg::sample_t                  ring_mem [RING_DEPTH];
  tsring_pkg::sample_t                  rd_data;
  logic                                 mem_we;
  logic [AW-1:0]                        mem_waddr;
  tsring_pkg::sample_t                  mem_wdata;
  logic [AW-1:0]                        mem_raddr;

  logic                                 in_fire;
  logic                                 out_free;
  logic [tsring_pkg::STAMP_W:0]         query_diff;
  logic [tsring_pkg::STAMP_W-1:0]       query_next;
  logic [CW:0]                          mid_sum;
  logic [CW:0]                          up_sum;
  logic [CW:0]                          dn_sum;
  logic [CW-1:0]                        mid;
  logic [CW-1:0]                        mid_up;
  logic [CW-1:0]                        mid_dn;
  logic                                 le;
  logic                                 step_more;

  // physical address of logical offset off from the head
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] head,
                                             input logic [CW-1:0] off);
    logic [AW:0] sum;
    sum = (AW+1)'(head) + (AW+1)'(off);
    if (sum >= (AW+1)'(RING_DEPTH)) begin
      sum = sum - (AW+1)'(RING_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // latency-adjusted query, saturating at zero
  assign query_diff = {1'b0, stamp}
                    - (tsring_pkg::STAMP_W+1)'(capture_latency);
  assign query_next = query_diff[tsring_pkg::STAMP_W] ? '0
                                                      : query_diff[tsring_pkg::STAMP_W-1:0];

  // search midpoints: current, and the next one for either compare outcome
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CW:1];
  assign up_sum  = {1'b0, mid} + {1'b0, hi};
  assign mid_up  = up_sum[CW:1];
  assign dn_sum  = {1'b0, lo} + {1'b0, mid};
  assign mid_dn  = dn_sum[CW:1];

  assign le        = (rd_data.stamp <= query);
  assign step_more = le ? ((hi - mid) > CW'(1)) : ((mid - lo) > CW'(1));

  // memory write port: record at head, or fill sweep
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = head_index;
    mem_wdata = '{stamp: stamp, payload: pose_payload};
    if (state == S_FILL) begin
      mem_we    = 1'b1;
      mem_waddr = fill_idx;
      mem_wdata = fill_word;
    end else if (in_fire && func == tsring_pkg::FUNC_RECORD) begin
      mem_we = 1'b1;
    end
  end

  // memory read address; outcome-selected so the next probe issues with the compare
  always_comb begin
    mem_raddr = ring_pos(head_index, lo);
    if (state == S_PROBE) begin
      mem_raddr = ring_pos(head_index, mid);
    end else if (state == S_STEP) begin
      if (le) begin
        mem_raddr = step_more ? ring_pos(head_index, mid_up) : ring_pos(head_index, mid);
      end else begin
        mem_raddr = step_more ? ring_pos(head_index, mid_dn) : ring_pos(head_index, lo);
      end
    end
  end

  // sample memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= ring_mem[mem_raddr];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      capture_latency <= tsring_pkg::LATENCY_RESET;
    end else if (cfg_wr_en) begin
      capture_latency <= cfg_wr_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head_index <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (func == tsring_pkg::FUNC_RECORD) begin
              head_index <= (head_index == AW'(RING_DEPTH - 1)) ? '0 : head_index + AW'(1);
            end else if (func == tsring_pkg::FUNC_FILL) begin
              head_index <= '0;
              state      <= S_FILL;
            end else if (func == tsring_pkg::FUNC_LOOKUP) begin
              state <= S_PROBE;
            end
          end
        end
        S_FILL: begin
          if (fill_idx == AW'(RING_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_PROBE: begin
          state <= S_STEP;
        end
        S_STEP: begin
          if (!step_more) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // search and fill datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      fill_idx  <= '0;
      fill_word <= '{stamp: stamp, payload: pose_payload};
      query     <= query_next;
      lo        <= '0;
      hi        <= CW'(RING_DEPTH);
    end else if (state == S_FILL) begin
      fill_idx <= fill_idx + AW'(1);
    end else if (state == S_STEP) begin
      if (le) begin
        lo <= mid;
      end else begin
        hi <= mid;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      found_payload <= rd_data.payload;
      found_stamp   <= rd_data.stamp;
    end
  end

endmodule

// ===== hw/rtl/tsring_checker.sv =====
module tsring_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [tsring_pkg::FUNC_W-1:0]    func,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [tsring_pkg::PAYLOAD_W-1:0] found_payload,
  input logic [tsring_pkg::STAMP_W-1:0]   found_stamp
);

  logic       lookup_in;
  logic       word_out;
  logic [1:0] pending;

  assign lookup_in = in_valid && !in_stall && func == tsring_pkg::FUNC_LOOKUP;
  assign word_out  = out_valid && !out_stall;

  // lookups taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(lookup_in) - 2'(word_out);
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid right after reset");

  a_out_has_lookup: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("output word without a pending lookup");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 2'd2)
    else $error("more than two lookups in flight");

  a_lookup_blocks: assert property (@(posedge clk) disable iff (rst)
    lookup_in |=> in_stall)
    else $error("input not stalled during lookup search");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found_payload) && $stable(found_stamp))
    else $error("stalled output word changed");

endmodule

bind timestamp_ring_nearest_lookup_core tsring_checker u_tsring_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .func         (func),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .found_payload(found_payload),
  .found_stamp  (found_stamp)
);

// ===== test/tsring_result_check.sv =====
module tsring_result_check #(
  parameter int unsigned RING_DEPTH = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [tsring_pkg::LAT_W-1:0]     cfg_wr_data,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [tsring_pkg::FUNC_W-1:0]    func,
  input  logic [tsring_pkg::STAMP_W-1:0]   stamp,
  input  logic [tsring_pkg::PAYLOAD_W-1:0] pose_payload,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [tsring_pkg::PAYLOAD_W-1:0] found_payload,
  input  logic [tsring_pkg::STAMP_W-1:0]   found_stamp,
  output int unsigned                      waiting,
  output int unsigned                      fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_REPORTS = 10;

  // shadow copy of the ring and its settings
  logic [tsring_pkg::STAMP_W-1:0]   ring_stamp   [RING_DEPTH];
  logic [tsring_pkg::PAYLOAD_W-1:0] ring_payload [RING_DEPTH];
  int unsigned                      head;
  logic [tsring_pkg::LAT_W-1:0]     latency;

  // lookup answers not yet seen on the output
  tsring_pkg::sample_t              due_results [$];
  tsring_pkg::sample_t              want;
  logic [tsring_pkg::STAMP_W-1:0]   query_time;

  function automatic int unsigned slot(int unsigned offset);
    return (head + offset) % RING_DEPTH;
  endfunction

  // newest entry (oldest first from head) whose stamp is not after the query,
  // else the oldest entry
  function automatic tsring_pkg::sample_t nearest_entry(
      logic [tsring_pkg::STAMP_W-1:0] query);
    int unsigned         lo;
    int unsigned         hi;
    int unsigned         mid;
    tsring_pkg::sample_t pick;
    lo = 0;
    hi = RING_DEPTH;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (ring_stamp[slot(mid)] <= query) lo = mid;
      else hi = mid;
    end
    pick.stamp   = ring_stamp[slot(lo)];
    pick.payload = ring_payload[slot(lo)];
    return pick;
  endfunction

  task automatic note_failure(string what, tsring_pkg::sample_t exp_word,
                              tsring_pkg::sample_t got_word);
    if (fail_count < MAX_REPORTS)
      $display("%0t %s: expected payload %h stamp %h, got payload %h stamp %h",
               $time, what, exp_word.payload, exp_word.stamp,
               got_word.payload, got_word.stamp);
    fail_count++;
  endtask

  initial begin
    waiting    = 0;
    fail_count = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_stamp[i]   = '0;
        ring_payload[i] = '0;
      end
      head    = 0;
      latency = tsring_pkg::LATENCY_RESET;
      due_results.delete();
    end else begin
      if (cfg_wr_en) latency = cfg_wr_data;

      // compare before pushing, so a stray word never meets its own lookup
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          want = '0;
          note_failure("unexpected word", want, {found_stamp, found_payload});
        end else begin
          want = due_results.pop_front();
          if (want.stamp !== found_stamp || want.payload !== found_payload)
            note_failure("mismatch", want, {found_stamp, found_payload});
        end
      end

      if (in_valid && !in_stall) begin
        case (func)
          tsring_pkg::FUNC_RECORD: begin
            ring_stamp[head]   = stamp;
            ring_payload[head] = pose_payload;
            head = slot(1);
          end
          tsring_pkg::FUNC_FILL: begin
            for (int i = 0; i < RING_DEPTH; i++) begin
              ring_stamp[i]   = stamp;
              ring_payload[i] = pose_payload;
            end
            head = 0;
          end
          tsring_pkg::FUNC_LOOKUP: begin
            // saturate at zero rather than wrap
            query_time = (stamp >= (tsring_pkg::STAMP_W)'(latency))
                       ? stamp - (tsring_pkg::STAMP_W)'(latency) : '0;
            due_results.push_back(nearest_entry(query_time));
          end
          default: ;
        endcase
      end
    end
    waiting = due_results.size();
  end

endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH         = 128;
  localparam logic [tsring_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  // a fill holds the block until every entry is written
  localparam int unsigned SETTLE_CYCLES = DEPTH + 24;
  localparam int unsigned PHASE_WORDS   = 240;
  localparam logic [tsring_pkg::STAMP_W-1:0] ALL_ONES = '1;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             cfg_wr_en;
  logic [tsring_pkg::LAT_W-1:0]     cfg_wr_data;
  logic                             in_valid;
  logic                             in_stall;
  logic [tsring_pkg::FUNC_W-1:0]    func;
  logic [tsring_pkg::STAMP_W-1:0]   stamp;
  logic [tsring_pkg::PAYLOAD_W-1:0] pose_payload;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [tsring_pkg::PAYLOAD_W-1:0] found_payload;
  logic [tsring_pkg::STAMP_W-1:0]   found_stamp;
  int unsigned                      waiting;
  int unsigned                      fail_count;

  // no idling on either side while set
  logic                             calm;
  logic [tsring_pkg::LAT_W-1:0]     lat_now;
  logic [tsring_pkg::STAMP_W-1:0]   clock_now;
  // stamps the ring should hold, oldest first
  logic [tsring_pkg::STAMP_W-1:0]   recent [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  timestamp_ring_nearest_lookup_core #(.RING_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .stamp(stamp), .pose_payload(pose_payload),
    .out_valid(out_valid), .out_stall(out_stall),
    .found_payload(found_payload), .found_stamp(found_stamp)
  );

  tsring_result_check #(.RING_DEPTH(DEPTH)) result_check (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .stamp(stamp), .pose_payload(pose_payload),
    .out_valid(out_valid), .out_stall(out_stall),
    .found_payload(found_payload), .found_stamp(found_stamp),
    .waiting(waiting), .fail_count(fail_count)
  );

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 17);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // present one word at a falling edge and hold it until taken
  task automatic send_word(logic [tsring_pkg::FUNC_W-1:0] f,
                           logic [tsring_pkg::STAMP_W-1:0] s,
                           logic [tsring_pkg::PAYLOAD_W-1:0] p);
    int unsigned gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 17) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    func         <= f;
    stamp        <= s;
    pose_payload <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (f == tsring_pkg::FUNC_RECORD) begin
      recent.push_back(s);
      if (recent.size() > DEPTH) void'(recent.pop_front());
    end else if (f == tsring_pkg::FUNC_FILL) begin
      recent.delete();
      recent.push_back(s);
    end
  endtask

  // drain, let any record or fill finish, then change the latency
  task automatic set_latency(logic [tsring_pkg::LAT_W-1:0] v);
    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    lat_now     = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly ordered recording with lookups aimed around stored stamps
  task automatic run_random(int unsigned count);
    int unsigned                    done;
    int unsigned                    pick;
    logic [tsring_pkg::STAMP_W-1:0] s;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        if ($urandom_range(3) != 0) clock_now += 64'($urandom_range(5000, 1));
        send_word(tsring_pkg::FUNC_RECORD, clock_now, rand64());
        done++;
      end else if (pick < 85) begin
        case ($urandom_range(9))
          0, 1: s = rand64();
          2: s = 64'($urandom_range(lat_now));
          default: s = recent[$urandom_range(recent.size() - 1)] + 64'(lat_now)
                       + 64'($urandom_range(2)) - 64'd1;
        endcase
        send_word(tsring_pkg::FUNC_LOOKUP, s, rand64());
        done++;
      end else if (pick < 90) begin
        send_word(tsring_pkg::FUNC_RECORD, rand64(), rand64());
        done++;
      end else if (pick < 93) begin
        clock_now = rand64() >> $urandom_range(63);
        send_word(tsring_pkg::FUNC_FILL, clock_now, rand64());
        done++;
      end else if (pick < 97) begin
        // ignored code, not counted
        send_word(FUNC_UNUSED, rand64(), rand64());
      end else begin
        send_word(tsring_pkg::FUNC_RECORD, ~64'($urandom_range(50)), rand64());
        done++;
      end
    end
  endtask

  initial begin
    logic [tsring_pkg::LAT_W-1:0] phase_lat [5];
    rst          = 1'b1;
    calm         = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    func         = tsring_pkg::FUNC_RECORD;
    stamp        = '0;
    pose_payload = '0;
    lat_now      = tsring_pkg::LATENCY_RESET;
    clock_now    = 64'd5000;
    phase_lat    = '{24'd0, 24'hFFFFFF, 24'($urandom), 24'd1, 24'($urandom_range(1000))};
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: ring must be filled before the first lookup
    send_word(tsring_pkg::FUNC_FILL, 64'd1000, ALL_ONES);
    send_word(tsring_pkg::FUNC_LOOKUP, 64'd0, '0);                  // saturates, none qualify
    send_word(tsring_pkg::FUNC_LOOKUP, 64'd33332, rand64());         // just under latency
    send_word(tsring_pkg::FUNC_LOOKUP, 64'd33333, rand64());         // query exactly zero
    send_word(tsring_pkg::FUNC_LOOKUP, 64'd1000 + 64'd33333, ALL_ONES); // all qualify
    send_word(tsring_pkg::FUNC_RECORD, 64'd2000, '0);
    send_word(tsring_pkg::FUNC_RECORD, 64'd3000, 64'hA5A5_5A5A_0F0F_F0F0);
    send_word(tsring_pkg::FUNC_RECORD, 64'd3000, 64'h5A5A_A5A5_F0F0_0F0F); // duplicate stamp
    send_word(tsring_pkg::FUNC_RECORD, ALL_ONES, '0);
    send_word(tsring_pkg::FUNC_LOOKUP, 64'd3000 + 64'd33333, '0);
    send_word(tsring_pkg::FUNC_LOOKUP, ALL_ONES, '0);
    send_word(FUNC_UNUSED, ALL_ONES, ALL_ONES);                      // ignored
    send_word(tsring_pkg::FUNC_LOOKUP, 64'd2999 + 64'd33333, '0);
    send_word(tsring_pkg::FUNC_FILL, 64'd0, '0);
    send_word(tsring_pkg::FUNC_LOOKUP, 64'd0, '0);                   // all stamps zero qualify
    send_word(tsring_pkg::FUNC_FILL, ALL_ONES, ALL_ONES);
    send_word(tsring_pkg::FUNC_LOOKUP, ALL_ONES, '0);                // nothing at or under query
    send_word(tsring_pkg::FUNC_RECORD, 64'd7, rand64());
    send_word(tsring_pkg::FUNC_LOOKUP, 64'd7 + 64'd33333, rand64());
    send_word(tsring_pkg::FUNC_FILL, clock_now, rand64());

    run_random(PHASE_WORDS - 10);
    for (int ph = 0; ph < 5; ph++) begin
      set_latency(phase_lat[ph]);
      calm = (ph == 2);
      run_random(PHASE_WORDS);
      calm = 1'b0;
    end
    in_valid <= 1'b0;

    while (waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && waiting == 0) begin
      $display("[timestamp_ring_nearest_lookup_core] OK");
    end else begin
      $display("[timestamp_ring_nearest_lookup_core] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("[timestamp_ring_nearest_lookup_core] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tsring_pkg.sv
hw/rtl/timestamp_ring_nearest_lookup_core.sv
hw/rtl/tsring_checker.sv
test/tsring_result_check.sv
test/tb.sv
